/* rtl/crn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crn_pkg
// Shared types and constants for the continuity residual norm block.
// ----------------------------------------------------------------------------
package crn_pkg;

  localparam int FracBitsDefault = 16;
  localparam int InW   = 24;
  localparam int AccW  = 64;
  localparam int MaxW  = 33;
  localparam int L2W   = 32;
  localparam int RelW  = 17;
  localparam int RelBits = 16;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SQRT,
    ST_DIVINT,
    ST_DIVFRAC,
    ST_OUT
  } crn_state_t;

  typedef struct packed {
    logic accumulate;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_frac_step;
    logic load_out;
    logic clear;
  } crn_cmd_t;

  typedef struct packed {
    logic cell_last;
    logic sqrt_done;
    logic div_int_done;
    logic div_frac_done;
  } crn_status_t;

endpackage

/* rtl/continuity_residual_norms_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continuity_residual_norms_top
// Streams cells and reports continuity residual norms per data set.
// ----------------------------------------------------------------------------
// Input channel: one cell word per accepted in_valid/in_ready handshake.
// Cells without last_cell are taken at one per cycle and produce nothing.
// On the word with last_cell, the cell is added, then input is held off
// while a load of the squared sum, a bit-serial square root (one result
// bit a cycle) and a restoring divider (an integer compare, then up to 16
// quotient bits, then a load of the result) run. The result word is then
// held on the output channel until taken; a stalled receiver holds the
// input off. Reset clears all accumulators and the sequencer.
// ----------------------------------------------------------------------------
module continuity_residual_norms_top
  import crn_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [InW-1:0] east_velocity,
  input  logic signed [InW-1:0] west_velocity,
  input  logic signed [InW-1:0] north_velocity,
  input  logic signed [InW-1:0] south_velocity,
  input  logic [InW-1:0]        east_area,
  input  logic [InW-1:0]        west_area,
  input  logic [InW-1:0]        north_area,
  input  logic [InW-1:0]        south_area,
  input  logic                  last_cell,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AccW-1:0]       l1_norm,
  output logic [L2W-1:0]        l2_norm,
  output logic [MaxW-1:0]       max_abs_imbalance,
  output logic [RelW-1:0]       relative_imbalance
);

  crn_cmd_t    cmd;
  crn_status_t status;

  crn_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  crn_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .east_velocity, .west_velocity, .north_velocity, .south_velocity,
    .east_area, .west_area, .north_area, .south_area, .last_cell,
    .l1_norm, .l2_norm, .max_abs_imbalance, .relative_imbalance
  );

endmodule

/* rtl/crn_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crn_ctrl
// Sequencer: accumulate, then run the square root and the divider per set.
// ----------------------------------------------------------------------------
module crn_ctrl
  import crn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  crn_status_t status,
  output crn_cmd_t    cmd
);

  crn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_RUN;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accumulate = 1'b1;
          if (status.cell_last) begin
            cmd.sqrt_start = 1'b1;
            state_next = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIVINT;
        end
      end
      ST_DIVINT: begin
        // integer part of l1/flux is found by one 64-bit compare
        if (status.div_int_done) state_next = ST_DIVFRAC;
      end
      ST_DIVFRAC: begin
        cmd.div_frac_step = 1'b1;
        if (status.div_frac_done) begin
          cmd.load_out = 1'b1;
          cmd.clear = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

endmodule

/* rtl/crn_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crn_dp
// Flux products, saturating accumulators, bit-serial sqrt and divider.
// ----------------------------------------------------------------------------
module crn_dp
  import crn_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  crn_cmd_t               cmd,
  output crn_status_t            status,
  input  logic signed [InW-1:0]  east_velocity,
  input  logic signed [InW-1:0]  west_velocity,
  input  logic signed [InW-1:0]  north_velocity,
  input  logic signed [InW-1:0]  south_velocity,
  input  logic [InW-1:0]         east_area,
  input  logic [InW-1:0]         west_area,
  input  logic [InW-1:0]         north_area,
  input  logic [InW-1:0]         south_area,
  input  logic                   last_cell,
  output logic [AccW-1:0]        l1_norm,
  output logic [L2W-1:0]         l2_norm,
  output logic [MaxW-1:0]        max_abs_imbalance,
  output logic [RelW-1:0]        relative_imbalance
);

  localparam int PW = 2 * InW;          // signed product width
  localparam int FW = PW - FRAC_BITS;   // flux width after shift
  localparam int IW = FW + 2;           // imbalance width

  logic signed [PW-1:0] pe, pw, pn, ps;
  logic signed [FW-1:0] fe, fw, fn, fs;
  logic signed [IW-1:0] imb;
  logic [IW-1:0] mag_imb;
  logic [AccW-1:0] a64, sq, fsum, a_sq_in;
  logic [MaxW-1:0] a33;
  logic sq_pend;

  assign pe = east_velocity  * $signed({1'b0, east_area});
  assign pw = west_velocity  * $signed({1'b0, west_area});
  assign pn = north_velocity * $signed({1'b0, north_area});
  assign ps = south_velocity * $signed({1'b0, south_area});
  // arithmetic shift floors toward minus infinity
  assign fe = FW'(pe >>> FRAC_BITS);
  assign fw = FW'(pw >>> FRAC_BITS);
  assign fn = FW'(pn >>> FRAC_BITS);
  assign fs = FW'(ps >>> FRAC_BITS);

  assign imb = IW'(fe) - IW'(fw) + IW'(fs) - IW'(fn);
  assign mag_imb = imb[IW-1] ? IW'(-imb) : IW'(imb);
  assign a64 = AccW'(mag_imb);

  function automatic logic [AccW-1:0] fmag(input logic signed [FW-1:0] f);
    fmag = f[FW-1] ? AccW'(-f) : AccW'(f);
  endfunction

  assign fsum = fmag(fe) + fmag(fw) + fmag(fn) + fmag(fs);

  // square the registered magnitude in the cycle after the cell is taken
  always_ff @(posedge clk) begin
    if (cmd.accumulate) a_sq_in <= a64;
  end

  assign sq = (a_sq_in[AccW-1:32] != '0) ? '1 : a_sq_in[31:0] * a_sq_in[31:0];
  assign a33 = (a64 > AccW'({MaxW{1'b1}})) ? '1 : a64[MaxW-1:0];

  function automatic logic [AccW-1:0] sat(input logic [AccW-1:0] x, input logic [AccW-1:0] y);
    logic [AccW:0] s;
    s = {1'b0, x} + {1'b0, y};
    sat = s[AccW] ? '1 : s[AccW-1:0];
  endfunction

  logic [AccW-1:0] abs_acc, sq_acc, flux_acc;
  logic [MaxW-1:0] max_acc;

  // isqrt: one result bit per cycle
  logic [AccW-1:0] sq_v, sq_res, sq_bit, sq_try;
  logic sq_prime;
  // divider: remainder plus carry bit
  logic [AccW-1:0] dv_num, dv_den, dv_r;
  logic [RelBits:0] dv_q;
  logic [4:0] dv_cnt;
  logic dv_int_seen;
  logic [AccW:0] dv_sh;

  assign sq_try = sq_res + sq_bit;
  assign dv_sh = {dv_r, 1'b0};

  assign status.cell_last     = last_cell;
  assign status.sqrt_done     = !sq_prime && ((sq_bit[1:0] == 2'b01) || (sq_bit == '0));
  assign status.div_int_done  = dv_int_seen;
  assign status.div_frac_done = (dv_cnt == 5'(RelBits)) || (dv_den == '0) || dv_q[RelBits];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      abs_acc <= '0;
      sq_acc <= '0;
      flux_acc <= '0;
      max_acc <= '0;
      sq_pend <= 1'b0;
    end else begin
      if (cmd.accumulate) begin
        abs_acc <= sat(abs_acc, a64);
        flux_acc <= sat(flux_acc, fsum);
        if (a33 > max_acc) max_acc <= a33;
      end
      if (sq_pend) sq_acc <= sat(sq_acc, sq);
      sq_pend <= cmd.accumulate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_prime <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
      sq_prime <= 1'b1;
    end else if (sq_prime) begin
      // fold in the square of the last cell before stepping
      sq_v <= sat(sq_acc, sq);
      sq_prime <= 1'b0;
    end else if (cmd.sqrt_step && sq_bit != '0) begin
      if (sq_v >= sq_try) begin
        sq_v <= sq_v - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    dv_int_seen <= 1'b0;
    if (cmd.accumulate) begin
      dv_num <= sat(abs_acc, a64);
      dv_den <= sat(flux_acc, fsum);
    end
    if (cmd.div_start) begin
      dv_cnt <= '0;
      dv_int_seen <= 1'b1;
      // l1 >= flux means a ratio of one or more: cap
      if (dv_den != '0 && dv_num >= dv_den) begin
        dv_q <= {1'b1, {RelBits{1'b0}}};
      end else begin
        dv_q <= '0;
      end
      dv_r <= dv_num;
    end else if (cmd.div_frac_step && !status.div_frac_done) begin
      dv_cnt <= dv_cnt + 5'd1;
      if (dv_sh[AccW] || dv_sh[AccW-1:0] >= dv_den) begin
        dv_r <= dv_sh[AccW-1:0] - dv_den;
        dv_q <= {dv_q[RelBits-1:0], 1'b1};
      end else begin
        dv_r <= dv_sh[AccW-1:0];
        dv_q <= {dv_q[RelBits-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      l1_norm <= dv_num;
      l2_norm <= sq_res[L2W-1:0];
      max_abs_imbalance <= max_acc;
      relative_imbalance <= (dv_den == '0) ? '0 : RelW'(dv_q);
    end
  end

endmodule

/* rtl/crn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crn_checker
// Port-level checks for the continuity residual norm block.
// ----------------------------------------------------------------------------
module crn_checker
  import crn_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            last_cell,
  input logic            out_valid,
  input logic            out_ready,
  input logic [AccW-1:0] l1_norm,
  input logic [RelW-1:0] relative_imbalance
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(l1_norm))
    else $error("result word dropped or changed");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_cell |=> !in_ready)
    else $error("input not held off after last cell");

  a_rel_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> relative_imbalance <= RelW'(1 << RelBits))
    else $error("relative imbalance above one");

endmodule

bind continuity_residual_norms_top crn_checker u_crn_checker (
  .clk, .rst, .in_valid, .in_ready, .last_cell, .out_valid, .out_ready,
  .l1_norm, .relative_imbalance
);
